@@ rtl/mtfp_pkg.sv @@
`default_nettype none

package mtfp_pkg;

    localparam int unsigned WORDS      = 9;
    localparam int unsigned WIDX_W     = $clog2(WORDS);
    localparam int unsigned IMU_BASE   = 3;

    localparam logic [7:0] HDR_START   = 8'd36;
    localparam logic [7:0] CODE_ATT    = 8'd108;
    localparam logic [7:0] CODE_IMU    = 8'd102;

    localparam logic [4:0] POS_MAX     = 5'd17;
    localparam logic [4:0] POS_CODE    = 5'd4;
    localparam logic [4:0] POS_DATA    = 5'd5;
    localparam logic [4:0] POS_ATT_END = 5'd10;
    localparam logic [4:0] POS_IMU_END = 5'd16;

    localparam logic KIND_ATT = 1'b0;
    localparam logic KIND_IMU = 1'b1;

    typedef logic [15:0] t_word;
    typedef t_word t_words [WORDS];

endpackage

`default_nettype wire

@@ rtl/msp_telemetry_frame_parser_unit.sv @@
// result path: the byte that completes a message passes the input register, then the result register
// throughput: one byte per cycle; the input register and the result register are the only
// stages, and a held result stalls the input register behind it
// reset: synchronous, active low; position, message code, working words and snapshot
// clear to zero, no request is pending afterwards
`default_nettype none

module msp_telemetry_frame_parser_unit
    import mtfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output      logic               o_stall,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic               i_hold,

    output      logic               o_valid,
    input  wire logic               i_stall,
    output      logic               o_frame_kind,
    output      logic signed [15:0] o_roll,
    output      logic signed [15:0] o_pitch,
    output      logic signed [15:0] o_yaw,
    output      logic signed [15:0] o_accel_x,
    output      logic signed [15:0] o_accel_y,
    output      logic signed [15:0] o_accel_z,
    output      logic signed [15:0] o_gyro_x,
    output      logic signed [15:0] o_gyro_y,
    output      logic signed [15:0] o_gyro_z
);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_byte;
    logic              r_hold;

    // frame state
    logic [4:0]        r_pos;
    logic [7:0]        r_code;
    t_words            r_work;
    t_words            r_snap;

    // result register
    logic              r_out_valid;
    logic              r_kind;

    logic              proceed;
    logic [4:0]        n_pos;
    logic [7:0]        n_code;
    logic              att_hit;
    logic              imu_hit;
    logic [4:0]        data_off;
    logic [WIDX_W-1:0] widx;
    t_word             wnew;
    t_words            n_work;
    t_words            n_snap;
    logic              done_att;
    logic              done_imu;

    assign proceed = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !proceed;

    always_comb begin
        if (r_byte == HDR_START) begin
            n_pos = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 5'd1;
        end else begin
            n_pos = r_pos;
        end

        if (r_byte == HDR_START) begin
            n_code = '0;
        end else if (n_pos == POS_CODE) begin
            n_code = r_byte;
        end else begin
            n_code = r_code;
        end

        att_hit = (n_code == CODE_ATT) && (n_pos >= POS_DATA) && (n_pos <= POS_ATT_END);
        imu_hit = !att_hit && (n_code == CODE_IMU) && (n_pos >= POS_DATA)
                  && (n_pos <= POS_IMU_END);

        // two bytes per word, low byte first
        data_off = n_pos - POS_DATA;
        if (att_hit) begin
            widx = WIDX_W'(data_off[4:1]);
        end else begin
            widx = WIDX_W'(data_off[4:1]) + WIDX_W'(IMU_BASE);
        end

        if (n_pos[0]) begin
            wnew = {8'h00, r_byte};
        end else begin
            wnew = {r_byte, r_work[widx][7:0]};
        end

        n_work = r_work;
        if (att_hit || imu_hit) begin
            n_work[widx] = wnew;
        end

        done_att = att_hit && (n_pos == POS_ATT_END) && !r_hold;
        done_imu = imu_hit && (n_pos == POS_IMU_END) && !r_hold;

        n_snap = r_snap;
        for (int i = 0; i < WORDS; i++) begin
            if ((done_att && i < IMU_BASE) || (done_imu && i >= IMU_BASE)) begin
                n_snap[i] = n_work[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_code      <= '0;
            for (int i = 0; i < WORDS; i++) begin
                r_work[i] <= '0;
                r_snap[i] <= '0;
            end
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (proceed) begin
                r_pos       <= n_pos;
                r_code      <= n_code;
                r_work      <= n_work;
                r_snap      <= n_snap;
                r_out_valid <= done_att || done_imu;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_byte <= i_byte_value;
            r_hold <= i_hold;
        end
        if (proceed && (done_att || done_imu)) begin
            r_kind <= done_imu ? KIND_IMU : KIND_ATT;
        end
    end

    // snapshot only moves when a new result is loaded, so it can drive the outputs directly
    assign o_valid      = r_out_valid;
    assign o_frame_kind = r_kind;
    assign o_roll       = $signed(r_snap[0]);
    assign o_pitch      = $signed(r_snap[1]);
    assign o_yaw        = $signed(r_snap[2]);
    assign o_accel_x    = $signed(r_snap[3]);
    assign o_accel_y    = $signed(r_snap[4]);
    assign o_accel_z    = $signed(r_snap[5]);
    assign o_gyro_x     = $signed(r_snap[6]);
    assign o_gyro_y     = $signed(r_snap[7]);
    assign o_gyro_z     = $signed(r_snap[8]);

endmodule

`default_nettype wire

@@ rtl/mtfp_checker.sv @@
`default_nettype none

module mtfp_checker
    import mtfp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic [7:0]         i_byte_value,
    input wire logic               i_hold,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_frame_kind,
    input wire logic signed [15:0] o_roll,
    input wire logic signed [15:0] o_gyro_z
);

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_kind) && $stable(o_roll)
                               && $stable(o_gyro_z))
        else $error("result changed while stalled");

    // nothing pending right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // a fresh result comes from an accepted request that had hold low, through the input and result registers
    a_rose_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_acc, 2) && !$past(i_hold, 2))
        else $error("result without a completing request");

    // the last byte of a message is never a frame start
    a_rose_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_byte_value, 2) != HDR_START)
        else $error("result from a frame start byte");

endmodule

bind msp_telemetry_frame_parser_unit mtfp_checker u_mtfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_byte_value (i_byte_value),
    .i_hold       (i_hold),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_frame_kind (o_frame_kind),
    .o_roll       (o_roll),
    .o_gyro_z     (o_gyro_z)
);

`default_nettype wire
